### rtl/pac_pkg.sv
// Package for the process admission controller: field widths, status and
// register codes, controller states and the structs between the modules.
// No dependencies.
package pac_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W     = 16;
    localparam int MEM_W    = 16;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 1;

    localparam logic [MEM_W-1:0] MEM_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] REG_SLOT_LIMIT   = 1'd0;
    localparam logic [CFG_AW-1:0] REG_MEM_CAPACITY = 1'd1;

    // Request codes
    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_KILL   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADMITTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KILLED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ADMIT_Q    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_SCAN,
        S_FREE,
        S_KILL_RES,
        S_EMIT2
    } t_state;

    // Job written into the first free slot or the queue tail
    typedef struct packed {
        logic             en;
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] mem;
    } t_job_wr;

    // Registered slot read data
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] mem;
    } t_slot_rd;

    // Queue status and head entry
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] mem;
    } t_q_stat;

endpackage

### rtl/pac_slots.sv
// Slot table: id and memory arrays in a synchronous memory with one write
// and one registered read port, valid bits in flops, first-free search.
// Depends on pac_pkg.
module pac_slots #(
    parameter int SLOTS = pac_pkg::SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pac_pkg::t_job_wr       i_wr,
    input  logic                   i_clr_en,
    input  logic [$clog2(SLOTS)-1:0] i_clr_addr,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output pac_pkg::t_slot_rd      o_rd,
    output logic                   o_any_free
);
    localparam int AW = $clog2(SLOTS);

    logic [pac_pkg::ID_W-1:0]  r_id_mem  [SLOTS];
    logic [pac_pkg::MEM_W-1:0] r_mem_mem [SLOTS];
    logic [SLOTS-1:0]          r_valid;
    logic [AW-1:0]             free_idx;
    logic                      any_free;

    // Lowest free slot wins
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = AW'(k);
                any_free = 1'b1;
            end
        end
    end

    assign o_any_free = any_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_wr.en && any_free) begin
                r_valid[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && any_free) begin
            r_id_mem[free_idx]  <= i_wr.id;
            r_mem_mem[free_idx] <= i_wr.mem;
        end
        o_rd.valid <= r_valid[i_rd_addr];
        o_rd.id    <= r_id_mem[i_rd_addr];
        o_rd.mem   <= r_mem_mem[i_rd_addr];
    end

endmodule

### rtl/pac_queue.sv
// FIFO wait queue: id and memory arrays in a synchronous memory, head and
// tail pointers and a fill count; the head entry is read every cycle.
// Depends on pac_pkg.
module pac_queue #(
    parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pac_pkg::t_job_wr i_push,
    input  logic             i_pop,
    output pac_pkg::t_q_stat o_stat
);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [pac_pkg::ID_W-1:0]  r_id_mem  [QUEUE_DEPTH];
    logic [pac_pkg::MEM_W-1:0] r_mem_mem [QUEUE_DEPTH];
    logic [QAW-1:0]            r_head;
    logic [QAW-1:0]            r_tail;
    logic [QCW-1:0]            r_count;
    logic [QAW-1:0]            n_head;
    logic [QAW-1:0]            n_tail;
    logic [QCW-1:0]            n_count;
    logic                      full;
    logic                      do_push;

    assign full    = (r_count == QCW'(QUEUE_DEPTH));
    assign do_push = i_push.en && !full;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail  = (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_pop && (r_count != '0)) begin
            n_head  = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_id_mem[r_tail]  <= i_push.id;
            r_mem_mem[r_tail] <= i_push.mem;
        end
        o_stat.id  <= r_id_mem[r_head];
        o_stat.mem <= r_mem_mem[r_head];
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = full;

endmodule

### rtl/process_admission_controller_unit.sv
// Process admission controller, top level: request FSM, memory accounting,
// result register. Depends on pac_pkg, pac_slots and pac_queue.
//
// A create item is decided in the cycle after it is accepted, and its result
// loads into the result register at the end of that cycle. The decision waits
// while an older result is still stalled. The block returns to idle, ready
// for the next item, as the result loads. A kill item walks the slot table
// through its single read port, one slot per cycle, then adds the freed
// memory back to the free memory and loads its first result; when the queue
// head is admitted, a second result follows. The block returns to idle,
// ready for the next item, as the last result loads. The result register
// lets the block take the next item while a result still waits under stall.
// Kill results carry the matched total (saturated at 65535); o_last is low
// only on a kill whose second result, the admitted queue head, follows. A
// running sum of the memory held by live slots lets a capacity write
// recompute the free memory at once. There is no clearing pass: slot valid
// bits reset in flops, and the queue entries are read only below the fill count.
module process_admission_controller_unit #(
    parameter int SLOTS       = pac_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [pac_pkg::ID_W-1:0]      i_job_id,
    input  logic [pac_pkg::MEM_W-1:0]     i_mem_need,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pac_pkg::STATUS_W-1:0]  o_status,
    output logic [pac_pkg::ID_W-1:0]      o_result_id,
    output logic [pac_pkg::MEM_W-1:0]     o_result_mem,
    output logic [pac_pkg::MEM_W-1:0]     o_free_memory,
    output logic                          o_last,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [pac_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [pac_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int AW     = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int USED_W = pac_pkg::MEM_W + $clog2(SLOTS);
    localparam int CMP_W  = (CNT_W > pac_pkg::LIMIT_W) ? CNT_W : pac_pkg::LIMIT_W;
    localparam int MW     = pac_pkg::MEM_W;
    localparam int SLOTS_RESET_LIMIT = 16;

    pac_pkg::t_state r_state, n_state;

    // configuration and accounting
    logic [pac_pkg::LIMIT_W-1:0] r_slot_limit, n_slot_limit;
    logic [MW-1:0]               r_capacity, n_capacity;
    logic [MW-1:0]               r_avail, n_avail;
    logic [USED_W-1:0]           r_used, n_used;
    logic [CNT_W-1:0]            r_running, n_running;

    // current item
    logic [pac_pkg::ID_W-1:0]    r_job_id, n_job_id;
    logic [MW-1:0]               r_mem_need, n_mem_need;

    // kill scan
    logic [CNT_W-1:0]            r_scan, n_scan;
    logic                        r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]               r_cmp_idx, n_cmp_idx;
    logic [MW-1:0]               r_freed, n_freed;
    logic                        r_found, n_found;

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [pac_pkg::STATUS_W-1:0] r_status, n_status;
    logic [pac_pkg::ID_W-1:0]    r_res_id, n_res_id;
    logic [MW-1:0]               r_res_mem, n_res_mem;
    logic [MW-1:0]               r_res_free, n_res_free;
    logic                        r_last, n_last;

    // submodule links
    pac_pkg::t_job_wr  slot_wr;
    pac_pkg::t_slot_rd slot_rd;
    logic              slot_clr_en;
    logic [AW-1:0]     slot_rd_addr;
    logic              any_free;
    pac_pkg::t_job_wr  q_push;
    logic              q_pop;
    pac_pkg::t_q_stat  q_stat;

    // decisions
    logic              in_acc;
    logic              out_free;
    logic              scan_end;
    logic              can_run;
    logic              head_admit;
    logic              hit;
    logic [MW:0]       freed_sum;
    logic [MW:0]       avail_sum;
    logic [USED_W:0]   cap_ext;

    assign in_acc   = i_in_valid && (r_state == pac_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_end = (r_scan == CNT_W'(SLOTS));
    // the limit register can exceed SLOTS; any_free caps the running count at SLOTS
    assign can_run  = any_free && (CMP_W'(r_running) < CMP_W'(r_slot_limit));
    assign head_admit = !q_stat.empty && can_run && (q_stat.mem <= r_avail);
    assign hit      = r_cmp_vld && slot_rd.valid && (slot_rd.id == r_job_id);
    assign freed_sum = {1'b0, r_freed} + {1'b0, slot_rd.mem};
    assign avail_sum = {1'b0, r_avail} + {1'b0, r_freed};
    assign cap_ext   = (USED_W + 1)'(r_capacity);
    assign slot_rd_addr = scan_end ? '0 : r_scan[AW-1:0];

    pac_slots #(
        .SLOTS(SLOTS)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (slot_wr),
        .i_clr_en   (slot_clr_en),
        .i_clr_addr (r_cmp_idx),
        .i_rd_addr  (slot_rd_addr),
        .o_rd       (slot_rd),
        .o_any_free (any_free)
    );

    pac_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pac_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_action == pac_pkg::ACT_KILL) ? pac_pkg::S_SCAN
                                                              : pac_pkg::S_CREATE;
                end
            end
            pac_pkg::S_CREATE: begin
                if (out_free) begin
                    n_state = pac_pkg::S_IDLE;
                end
            end
            pac_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = pac_pkg::S_FREE;
                end
            end
            pac_pkg::S_FREE: begin
                n_state = pac_pkg::S_KILL_RES;
            end
            pac_pkg::S_KILL_RES: begin
                if (out_free) begin
                    n_state = head_admit ? pac_pkg::S_EMIT2 : pac_pkg::S_IDLE;
                end
            end
            pac_pkg::S_EMIT2: begin
                if (out_free) begin
                    n_state = pac_pkg::S_IDLE;
                end
            end
            default: n_state = pac_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_slot_limit = r_slot_limit;
        n_capacity   = r_capacity;
        n_avail      = r_avail;
        n_used       = r_used;
        n_running    = r_running;
        n_job_id     = r_job_id;
        n_mem_need   = r_mem_need;
        n_scan       = r_scan;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_freed      = r_freed;
        n_found      = r_found;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_res_id     = r_res_id;
        n_res_mem    = r_res_mem;
        n_res_free   = r_res_free;
        n_last       = r_last;
        slot_wr      = '0;
        slot_clr_en  = 1'b0;
        q_push       = '0;
        q_pop        = 1'b0;

        // configuration should be written only while idle; the block itself does not enforce this
        if (i_cfg_we) begin
            case (i_cfg_index)
                pac_pkg::REG_SLOT_LIMIT: begin
                    n_slot_limit = i_cfg_data[pac_pkg::LIMIT_W-1:0];
                end
                pac_pkg::REG_MEM_CAPACITY: begin
                    n_capacity = i_cfg_data[MW-1:0];
                    // floor at zero when live jobs already exceed the budget
                    if (r_used >= USED_W'(i_cfg_data[MW-1:0])) begin
                        n_avail = '0;
                    end else begin
                        n_avail = i_cfg_data[MW-1:0] - r_used[MW-1:0];
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            pac_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_job_id   = i_job_id;
                    n_mem_need = i_mem_need;
                    n_scan     = '0;
                    n_freed    = '0;
                    n_found    = 1'b0;
                end
            end
            pac_pkg::S_CREATE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res_id    = r_job_id;
                    n_res_mem   = '0;
                    n_res_free  = r_avail;
                    n_last      = 1'b1;
                    if (cap_ext < (USED_W + 1)'(r_mem_need)) begin
                        n_status = pac_pkg::ST_REJECTED;
                    end else if (can_run && (r_mem_need <= r_avail)) begin
                        n_status    = pac_pkg::ST_ADMITTED;
                        n_res_mem   = r_mem_need;
                        n_res_free  = r_avail - r_mem_need;
                        n_avail     = r_avail - r_mem_need;
                        n_used      = r_used + USED_W'(r_mem_need);
                        n_running   = r_running + 1'b1;
                        slot_wr     = '{en: 1'b1, id: r_job_id, mem: r_mem_need};
                    end else if (!q_stat.full) begin
                        n_status = pac_pkg::ST_QUEUED;
                        q_push   = '{en: 1'b1, id: r_job_id, mem: r_mem_need};
                    end else begin
                        n_status = pac_pkg::ST_QUEUE_FULL;
                    end
                end
            end
            pac_pkg::S_SCAN: begin
                // issue the read of one slot, compare the one read last cycle
                if (!scan_end) begin
                    n_scan    = r_scan + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[AW-1:0];
                end
                if (hit) begin
                    slot_clr_en = 1'b1;
                    n_found     = 1'b1;
                    n_running   = r_running - 1'b1;
                    n_used      = r_used - USED_W'(slot_rd.mem);
                    n_freed     = freed_sum[MW] ? pac_pkg::MEM_MAX : freed_sum[MW-1:0];
                end
            end
            pac_pkg::S_FREE: begin
                n_avail = avail_sum[MW] ? pac_pkg::MEM_MAX : avail_sum[MW-1:0];
            end
            pac_pkg::S_KILL_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_found ? pac_pkg::ST_KILLED : pac_pkg::ST_NOT_FOUND;
                    n_res_id    = r_job_id;
                    n_res_mem   = r_freed;
                    n_res_free  = r_avail;
                    n_last      = !head_admit;
                    if (head_admit) begin
                        q_pop      = 1'b1;
                        slot_wr    = '{en: 1'b1, id: q_stat.id, mem: q_stat.mem};
                        n_avail    = r_avail - q_stat.mem;
                        n_used     = r_used + USED_W'(q_stat.mem);
                        n_running  = r_running + 1'b1;
                        n_job_id   = q_stat.id;
                        n_mem_need = q_stat.mem;
                    end
                end
            end
            pac_pkg::S_EMIT2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = pac_pkg::ST_ADMIT_Q;
                    n_res_id    = r_job_id;
                    n_res_mem   = r_mem_need;
                    n_res_free  = r_avail;
                    n_last      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pac_pkg::S_IDLE;
            r_slot_limit <= pac_pkg::LIMIT_W'(SLOTS_RESET_LIMIT);
            r_capacity   <= pac_pkg::MEM_MAX;
            r_avail      <= pac_pkg::MEM_MAX;
            r_used       <= '0;
            r_running    <= '0;
            r_scan       <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_freed      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_limit <= n_slot_limit;
            r_capacity   <= n_capacity;
            r_avail      <= n_avail;
            r_used       <= n_used;
            r_running    <= n_running;
            r_scan       <= n_scan;
            r_cmp_vld    <= n_cmp_vld;
            r_found      <= n_found;
            r_freed      <= n_freed;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_job_id   <= n_job_id;
        r_mem_need <= n_mem_need;
        r_cmp_idx  <= n_cmp_idx;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_mem  <= n_res_mem;
        r_res_free <= n_res_free;
        r_last     <= n_last;
    end

    assign o_in_stall    = (r_state != pac_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_id   = r_res_id;
    assign o_result_mem  = r_res_mem;
    assign o_free_memory = r_res_free;
    assign o_last        = r_last;

endmodule

### rtl/pac_checker.sv
// Port-level checker for the process admission controller and the bind
// that attaches it to the top level. Depends on pac_pkg.
module pac_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pac_pkg::STATUS_W-1:0]  o_status,
    input logic [pac_pkg::ID_W-1:0]      o_result_id,
    input logic [pac_pkg::MEM_W-1:0]     o_result_mem,
    input logic [pac_pkg::MEM_W-1:0]     o_free_memory,
    input logic                          o_last
);

    // only a kill result may be followed by a second result
    a_first_is_kill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |->
            (o_status == pac_pkg::ST_KILLED || o_status == pac_pkg::ST_NOT_FOUND))
        else $error("non-final result is not a kill result");

    // an admission from the queue always ends the item
    a_adm_q_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == pac_pkg::ST_ADMIT_Q) |-> o_last)
        else $error("queue admission not marked last");

    // results that move no memory report zero
    a_zero_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == pac_pkg::ST_QUEUED
                         || o_status == pac_pkg::ST_NOT_FOUND
                         || o_status == pac_pkg::ST_REJECTED
                         || o_status == pac_pkg::ST_QUEUE_FULL))
            |-> (o_result_mem == '0))
        else $error("nonzero memory on a result that moves none");

    // one item at a time: an accepted item stalls the request side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request side not stalled after accepting an item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_result_id)
             && $stable(o_result_mem) && $stable(o_free_memory) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind process_admission_controller_unit pac_checker u_pac_checker (.*);
